@@ hw/rtl/ising_pkg.sv @@
// ----------------------------------------------------------------------------
// ising_pkg
// Shared widths, codes, types and a helper function for the Ising spin-flip
// core.
// ----------------------------------------------------------------------------
package ising_pkg;

    // Default lattice geometry and random fraction width.
    localparam int LATTICE_WIDTH_DEF  = 64;
    localparam int LATTICE_HEIGHT_DEF = 64;
    localparam int RANDOM_BITS_DEF    = 16;

    // Fixed field widths of the word interfaces.
    localparam int SITE_W   = 12;
    localparam int RND_W    = 16;
    localparam int THR_W    = 16;
    localparam int DELTA_W  = 5;
    localparam int MAG_W    = 14;
    localparam int ENERGY_W = 15;
    localparam int CFG_IDX_W = 1;

    // Fraction bits of the reciprocal used to split a site into row and column.
    localparam int RECIP_SHIFT = 24;

    // Operation codes carried in the func field.
    localparam logic FUNC_PROPOSE = 1'b0;
    localparam logic FUNC_WRITE   = 1'b1;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_FOUR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_EIGHT = 1'b1;

    // Energy changes of a single flip, in units of J.
    localparam logic signed [DELTA_W-1:0] DELTA_NEG_EIGHT = -5'sd8;
    localparam logic signed [DELTA_W-1:0] DELTA_NEG_FOUR  = -5'sd4;
    localparam logic signed [DELTA_W-1:0] DELTA_ZERO      = 5'sd0;
    localparam logic signed [DELTA_W-1:0] DELTA_FOUR      = 5'sd4;
    localparam logic signed [DELTA_W-1:0] DELTA_EIGHT     = 5'sd8;

    // Outcome of evaluating one item against the lattice.
    typedef struct packed {
        logic                       flip;
        logic signed [DELTA_W-1:0]  delta;
        logic                       new_spin;
    } ising_eval_t;

    // Energy change of flipping a spin, given how many of its four
    // neighbours point up.
    function automatic logic signed [DELTA_W-1:0] delta_of(
        input logic       spin,
        input logic [2:0] up_count
    );
        logic signed [DELTA_W-1:0] d_up;
        case (up_count)
            3'd0:    d_up = DELTA_NEG_EIGHT;
            3'd1:    d_up = DELTA_NEG_FOUR;
            3'd2:    d_up = DELTA_ZERO;
            3'd3:    d_up = DELTA_FOUR;
            default: d_up = DELTA_EIGHT;
        endcase
        return spin ? d_up : -d_up;
    endfunction

endpackage

@@ hw/rtl/ising_ram.sv @@
// ----------------------------------------------------------------------------
// ising_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ising_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ising_addr.sv @@
// ----------------------------------------------------------------------------
// ising_addr
// Splits a linear site index into its row and the two wrapped neighbour
// rows, and flags sites beyond the lattice.
// ----------------------------------------------------------------------------
module ising_addr
    import ising_pkg::*;
#(
    parameter int LATTICE_WIDTH  = LATTICE_WIDTH_DEF,
    parameter int LATTICE_HEIGHT = LATTICE_HEIGHT_DEF
) (
    input  logic [SITE_W-1:0]                 site,
    output logic                              in_range,
    output logic [$clog2(LATTICE_HEIGHT)-1:0] row,
    output logic [$clog2(LATTICE_HEIGHT)-1:0] row_up,
    output logic [$clog2(LATTICE_HEIGHT)-1:0] row_dn
);

    localparam int ROW_W = $clog2(LATTICE_HEIGHT);
    localparam longint unsigned SITE_COUNT =
        longint'(LATTICE_WIDTH) * longint'(LATTICE_HEIGHT);
    // Rounded-up reciprocal of the width; exact for every 12-bit site.
    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / LATTICE_WIDTH + 64'd1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(LATTICE_HEIGHT - 1);

    logic [47:0] prod;

    assign in_range = 64'(site) < SITE_COUNT;
    assign prod     = 48'(site) * 48'(RECIP);
    assign row      = prod[RECIP_SHIFT +: ROW_W];
    assign row_up   = (row == ROW_LAST) ? '0 : row + ROW_W'(1);
    assign row_dn   = (row == '0) ? ROW_LAST : row - ROW_W'(1);

endmodule

@@ hw/rtl/ising_eval.sv @@
// ----------------------------------------------------------------------------
// ising_eval
// Picks the site and its four neighbours out of three lattice rows, forms
// the flip energy, makes the Metropolis or write decision and builds the
// updated row.
// ----------------------------------------------------------------------------
module ising_eval
    import ising_pkg::*;
#(
    parameter int LATTICE_WIDTH  = LATTICE_WIDTH_DEF,
    parameter int LATTICE_HEIGHT = LATTICE_HEIGHT_DEF,
    parameter int RANDOM_BITS    = RANDOM_BITS_DEF
) (
    input  logic [SITE_W-1:0]                 site,
    input  logic [$clog2(LATTICE_HEIGHT)-1:0] row,
    input  logic                              in_range,
    input  logic                              func,
    input  logic [RND_W-1:0]                  rnd,
    input  logic                              spin_value,
    input  logic [THR_W-1:0]                  thr_four,
    input  logic [THR_W-1:0]                  thr_eight,
    input  logic [LATTICE_WIDTH-1:0]          row_dn_data,
    input  logic [LATTICE_WIDTH-1:0]          row_mid_data,
    input  logic [LATTICE_WIDTH-1:0]          row_up_data,
    output ising_eval_t                       res,
    output logic [LATTICE_WIDTH-1:0]          wr_data
);

    localparam int COL_W = $clog2(LATTICE_WIDTH);
    localparam int CMP_W = RND_W + THR_W + RANDOM_BITS;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(LATTICE_WIDTH - 1);
    localparam logic [RND_W-1:0] RND_MASK = (RANDOM_BITS >= RND_W) ?
        {RND_W{1'b1}} : RND_W'((64'd1 << RANDOM_BITS) - 64'd1);

    logic [31:0]               col_full;
    logic [COL_W-1:0]          col;
    logic [COL_W-1:0]          col_l;
    logic [COL_W-1:0]          col_r;
    logic                      spin;
    logic [2:0]                up_count;
    logic signed [DELTA_W-1:0] delta;
    logic [THR_W-1:0]          thr;
    logic [CMP_W-1:0]          lhs;
    logic [CMP_W-1:0]          rhs;
    logic                      below;
    logic                      flip_ok;

    always_comb
    begin
        col_full = 32'(site) - 32'(row) * 32'(LATTICE_WIDTH);
        col      = col_full[COL_W-1:0];
        col_l    = (col == '0) ? COL_LAST : col - COL_W'(1);
        col_r    = (col == COL_LAST) ? '0 : col + COL_W'(1);

        spin     = row_mid_data[col];
        up_count = 3'(row_mid_data[col_l]) + 3'(row_mid_data[col_r])
                 + 3'(row_up_data[col]) + 3'(row_dn_data[col]);
        delta    = delta_of(spin, up_count);

        // A rise is taken when the random fraction lies below the threshold.
        thr   = (delta == DELTA_EIGHT) ? thr_eight : thr_four;
        lhs   = CMP_W'(rnd & RND_MASK) << RND_W;
        rhs   = CMP_W'(thr) << RANDOM_BITS;
        below = lhs < rhs;

        if (func == FUNC_PROPOSE)
        begin
            flip_ok = (delta <= DELTA_ZERO) || below;
        end
        else
        begin
            flip_ok = spin != spin_value;
        end

        res.flip     = in_range && flip_ok;
        res.delta    = in_range ? delta : DELTA_ZERO;
        res.new_spin = ~spin;

        wr_data      = row_mid_data;
        wr_data[col] = ~spin;
    end

endmodule

@@ hw/rtl/ising_metropolis_spin_flip_core.sv @@
// ----------------------------------------------------------------------------
// ising_metropolis_spin_flip_core
// Two-dimensional periodic Ising lattice with Metropolis single-spin flips.
//
// The core holds LATTICE_WIDTH x LATTICE_HEIGHT spins and takes one word per
// clock cycle once it is ready and the result channel is not stalled: a
// propose word flips a site when the energy change is zero or less, or when
// the random fraction lies below the threshold register for a rise of four
// or eight J; a write word sets a site to a given spin. Each word yields
// exactly one result word, presented from the result register after the
// work stage, carrying whether the spin changed, the flip energy and the
// running magnetization and energy totals. The lattice is kept as three
// identical row-wide RAMs, so that the site row and both neighbour rows are
// read in the same cycle, each through its own single read port; that is
// what sustains one word per cycle. A write that lands on the row just read
// is forwarded from a register, so consecutive words on the same rows need
// no gap. After reset the core sets every row to spin up in a clearing
// pass and holds in_stall high meanwhile; the threshold registers
// can be written at any time and should be written only while the core is
// idle.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_flip_core
    import ising_pkg::*;
#(
    parameter int LATTICE_WIDTH  = LATTICE_WIDTH_DEF,
    parameter int LATTICE_HEIGHT = LATTICE_HEIGHT_DEF,
    parameter int RANDOM_BITS    = RANDOM_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,

    // Configuration write channel.
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [THR_W-1:0]           cfg_data,

    // Input word channel.
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [SITE_W-1:0]          site,
    input  logic [RND_W-1:0]           random,
    input  logic                       spin_value,

    // Result word channel.
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       accepted,
    output logic signed [DELTA_W-1:0]  delta_energy,
    output logic signed [MAG_W-1:0]    total_magnetization,
    output logic signed [ENERGY_W-1:0] total_energy
);

    localparam int ROW_W = $clog2(LATTICE_HEIGHT);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(LATTICE_HEIGHT - 1);
    localparam longint SITE_COUNT = longint'(LATTICE_WIDTH) * longint'(LATTICE_HEIGHT);
    localparam logic signed [MAG_W-1:0]    MAG_RESET    = MAG_W'(SITE_COUNT);
    localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * SITE_COUNT);
    localparam logic signed [MAG_W-1:0]    MAG_STEP     = MAG_W'(2);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [ROW_W-1:0] clr_cnt_reg;
    logic [ROW_W-1:0] clr_cnt_next;

    logic [THR_W-1:0] thr_four_reg;
    logic [THR_W-1:0] thr_eight_reg;

    // Work stage: the accepted word and the rows it asked for.
    logic              s1_valid_reg;
    logic [SITE_W-1:0] s1_site_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [ROW_W-1:0]  s1_row_up_reg;
    logic [ROW_W-1:0]  s1_row_dn_reg;
    logic              s1_in_range_reg;
    logic              s1_func_reg;
    logic [RND_W-1:0]  s1_rnd_reg;
    logic              s1_spin_reg;

    // Last row written back, for reads that raced the write.
    logic                     fwd_valid_reg;
    logic [ROW_W-1:0]         fwd_row_reg;
    logic [LATTICE_WIDTH-1:0] fwd_data_reg;

    // Running totals and the result register.
    logic signed [MAG_W-1:0]    mag_reg;
    logic signed [MAG_W-1:0]    mag_next;
    logic signed [ENERGY_W-1:0] energy_reg;
    logic signed [ENERGY_W-1:0] energy_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       accepted_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic signed [MAG_W-1:0]    out_mag_reg;
    logic signed [ENERGY_W-1:0] out_energy_reg;

    logic                     in_accept;
    logic                     s1_fire;
    logic                     a_in_range;
    logic [ROW_W-1:0]         a_row;
    logic [ROW_W-1:0]         a_row_up;
    logic [ROW_W-1:0]         a_row_dn;
    logic [LATTICE_WIDTH-1:0] q_dn;
    logic [LATTICE_WIDTH-1:0] q_mid;
    logic [LATTICE_WIDTH-1:0] q_up;
    logic [LATTICE_WIDTH-1:0] row_dn_data;
    logic [LATTICE_WIDTH-1:0] row_mid_data;
    logic [LATTICE_WIDTH-1:0] row_up_data;
    logic [LATTICE_WIDTH-1:0] eval_wr_data;
    ising_eval_t              eval_res;
    logic                     ram_we;
    logic [ROW_W-1:0]         ram_waddr;
    logic [LATTICE_WIDTH-1:0] ram_wdata;

    // ------------------------------------------------------------------
    // Handshakes. The work stage moves on whenever the result register is
    // empty or being emptied, and a new word enters behind it in the same
    // cycle.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = (state_reg != ST_RUN) || (s1_valid_reg && !s1_fire);
    assign in_accept = in_valid && !in_stall;

    // ------------------------------------------------------------------
    // Row decode of the incoming site and the three lattice copies.
    // ------------------------------------------------------------------
    ising_addr #(
        .LATTICE_WIDTH  (LATTICE_WIDTH),
        .LATTICE_HEIGHT (LATTICE_HEIGHT)
    ) u_addr (
        .site     (site),
        .in_range (a_in_range),
        .row      (a_row),
        .row_up   (a_row_up),
        .row_dn   (a_row_dn)
    );

    // During the clearing pass every row is written with all spins up;
    // afterwards the work stage writes back the row of each flipped site.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = {LATTICE_WIDTH{1'b1}};
        end
        else
        begin
            ram_we    = s1_fire && eval_res.flip;
            ram_waddr = s1_row_reg;
            ram_wdata = eval_wr_data;
        end
    end

    ising_ram #(
        .DATA_W (LATTICE_WIDTH),
        .DEPTH  (LATTICE_HEIGHT)
    ) u_ram_dn (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (a_row_dn),
        .rdata (q_dn)
    );

    ising_ram #(
        .DATA_W (LATTICE_WIDTH),
        .DEPTH  (LATTICE_HEIGHT)
    ) u_ram_mid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (a_row),
        .rdata (q_mid)
    );

    ising_ram #(
        .DATA_W (LATTICE_WIDTH),
        .DEPTH  (LATTICE_HEIGHT)
    ) u_ram_up (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (a_row_up),
        .rdata (q_up)
    );

    // The forward register always holds the most recent write, so where its
    // row matches it is never older than the RAM contents.
    assign row_dn_data  = (fwd_valid_reg && fwd_row_reg == s1_row_dn_reg) ? fwd_data_reg : q_dn;
    assign row_mid_data = (fwd_valid_reg && fwd_row_reg == s1_row_reg)    ? fwd_data_reg : q_mid;
    assign row_up_data  = (fwd_valid_reg && fwd_row_reg == s1_row_up_reg) ? fwd_data_reg : q_up;

    ising_eval #(
        .LATTICE_WIDTH  (LATTICE_WIDTH),
        .LATTICE_HEIGHT (LATTICE_HEIGHT),
        .RANDOM_BITS    (RANDOM_BITS)
    ) u_eval (
        .site         (s1_site_reg),
        .row          (s1_row_reg),
        .in_range     (s1_in_range_reg),
        .func         (s1_func_reg),
        .rnd          (s1_rnd_reg),
        .spin_value   (s1_spin_reg),
        .thr_four     (thr_four_reg),
        .thr_eight    (thr_eight_reg),
        .row_dn_data  (row_dn_data),
        .row_mid_data (row_mid_data),
        .row_up_data  (row_up_data),
        .res          (eval_res),
        .wr_data      (eval_wr_data)
    );

    // ------------------------------------------------------------------
    // Clearing sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ROW_W'(1);
                if (clr_cnt_reg == ROW_LAST)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Totals and result handshake.
    // ------------------------------------------------------------------
    always_comb
    begin
        mag_next    = mag_reg;
        energy_next = energy_reg;
        if (s1_fire && eval_res.flip)
        begin
            mag_next    = eval_res.new_spin ? mag_reg + MAG_STEP : mag_reg - MAG_STEP;
            energy_next = energy_reg
                        + {{(ENERGY_W - DELTA_W){eval_res.delta[DELTA_W-1]}}, eval_res.delta};
        end

        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            thr_four_reg  <= '0;
            thr_eight_reg <= '0;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            mag_reg       <= MAG_RESET;
            energy_reg    <= ENERGY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            mag_reg       <= mag_next;
            energy_reg    <= energy_next;
            out_valid_reg <= out_valid_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_THRESH_FOUR:  thr_four_reg  <= cfg_data;
                    REG_THRESH_EIGHT: thr_eight_reg <= cfg_data;
                    default:          ;
                endcase
            end

            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (state_reg == ST_RUN && ram_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_site_reg     <= site;
            s1_row_reg      <= a_row;
            s1_row_up_reg   <= a_row_up;
            s1_row_dn_reg   <= a_row_dn;
            s1_in_range_reg <= a_in_range;
            s1_func_reg     <= func;
            s1_rnd_reg      <= random;
            s1_spin_reg     <= spin_value;
        end

        if (state_reg == ST_RUN && ram_we)
        begin
            fwd_row_reg  <= s1_row_reg;
            fwd_data_reg <= eval_wr_data;
        end

        if (s1_fire)
        begin
            accepted_reg   <= eval_res.flip;
            delta_reg      <= eval_res.delta;
            out_mag_reg    <= mag_next;
            out_energy_reg <= energy_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign accepted            = accepted_reg;
    assign delta_energy        = delta_reg;
    assign total_magnetization = out_mag_reg;
    assign total_energy        = out_energy_reg;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Ising Metropolis spin-flip core. A scoreboard
// keeps its own copy of the lattice, the totals and the thresholds, predicts
// one result word per accepted word and checks every result word against the
// oldest prediction. Directed words walk through the wrap-around
// neighbourhoods and every energy change. Random phases then run under
// several threshold settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import ising_pkg::*;

    localparam int LW          = LATTICE_WIDTH_DEF;
    localparam int LH          = LATTICE_HEIGHT_DEF;
    localparam int SITES       = LW * LH;
    localparam int RB          = RANDOM_BITS_DEF;
    localparam int PIPE_DEPTH  = 2;
    localparam int SETTLE      = PIPE_DEPTH + 3;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASES      = 6;
    localparam int PHASE_WORDS = 150;

    // One word on the input channel.
    typedef struct packed {
        logic              func;
        logic [SITE_W-1:0] site;
        logic [RND_W-1:0]  frac;
        logic              spin;
    } spin_word_t;

    // One word on the result channel.
    typedef struct {
        logic                       accepted;
        logic signed [DELTA_W-1:0]  delta;
        logic signed [MAG_W-1:0]    magnetisation;
        logic signed [ENERGY_W-1:0] energy;
    } flip_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: lattice predictor plus the queue of predicted result words.
    // ------------------------------------------------------------------------
    class spin_flip_scoreboard;
        bit             spins[SITES];
        int             magnetisation;
        int             energy;
        bit [THR_W-1:0] thresh_four;
        bit [THR_W-1:0] thresh_eight;
        flip_result_t   predicted_q[$];
        int             errors;
        int             checked;
        int             flips;

        function new();
            foreach (spins[i]) spins[i] = 1'b1;
            magnetisation = SITES;
            energy        = -2 * SITES;
            thresh_four   = '0;
            thresh_eight  = '0;
            errors        = 0;
            checked       = 0;
            flips         = 0;
        endfunction

        function void set_threshold(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
            if (idx == REG_THRESH_FOUR)
                thresh_four = data;
            else if (idx == REG_THRESH_EIGHT)
                thresh_eight = data;
        endfunction

        function int spin_of(int idx);
            return spins[idx] ? 1 : -1;
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        // Works out the result word that an accepted word must produce.
        function void note_word(spin_word_t w);
            int           col;
            int           row;
            int           nsum;
            int           delta;
            bit           take;
            logic [63:0]  frac;
            logic [63:0]  limit;
            flip_result_t r;
            delta = 0;
            take  = 1'b0;
            if (w.site < SITES)
            begin
                col  = w.site % LW;
                row  = w.site / LW;
                nsum = spin_of((col + LW - 1) % LW + row * LW)
                     + spin_of((col + 1) % LW + row * LW)
                     + spin_of(col + ((row + 1) % LH) * LW)
                     + spin_of(col + ((row + LH - 1) % LH) * LW);
                delta = 2 * spin_of(w.site) * nsum;
                if (w.func == FUNC_PROPOSE)
                begin
                    if (delta <= 0)
                    begin
                        take = 1'b1;
                    end
                    else
                    begin
                        frac  = 64'(w.frac) & ((64'd1 << RB) - 64'd1);
                        limit = (delta >= 8) ? 64'(thresh_eight) : 64'(thresh_four);
                        take  = (frac << 16) < (limit << RB);
                    end
                end
                else
                begin
                    take = (spins[w.site] != w.spin);
                end
                if (take)
                begin
                    spins[w.site] = ~spins[w.site];
                    magnetisation += 2 * spin_of(w.site);
                    energy        += delta;
                    flips++;
                end
            end
            r.accepted      = take;
            r.delta         = DELTA_W'(delta);
            r.magnetisation = MAG_W'(magnetisation);
            r.energy        = ENERGY_W'(energy);
            predicted_q.push_back(r);
        endfunction

        // Compares one result word with the oldest prediction.
        function void check_result(flip_result_t got);
            flip_result_t exp;
            if (predicted_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result word with nothing predicted (acc=%0d dE=%0d)",
                             $realtime, got.accepted, got.delta);
                return;
            end
            exp = predicted_q.pop_front();
            checked++;
            if (got.accepted !== exp.accepted || got.delta !== exp.delta ||
                got.magnetisation !== exp.magnetisation || got.energy !== exp.energy)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: mismatch, expected acc=%0d dE=%0d M=%0d E=%0d",
                             $realtime, exp.accepted, exp.delta, exp.magnetisation,
                             exp.energy);
                    $display("    got acc=%0d dE=%0d M=%0d E=%0d",
                             got.accepted, got.delta, got.magnetisation, got.energy);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the core starts at a known value.
    // ------------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n      = 1'b0;
    logic                       cfg_valid  = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index  = REG_THRESH_FOUR;
    logic [THR_W-1:0]           cfg_data   = '0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic                       func       = FUNC_PROPOSE;
    logic [SITE_W-1:0]          site       = '0;
    logic [RND_W-1:0]           random     = '0;
    logic                       spin_value = 1'b0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic                       accepted;
    logic signed [DELTA_W-1:0]  delta_energy;
    logic signed [MAG_W-1:0]    total_magnetization;
    logic signed [ENERGY_W-1:0] total_energy;

    spin_flip_scoreboard sb;
    flip_result_t        seen_result;
    int                  send_idle_pct = 0;
    int                  stall_pct     = 0;
    int                  quiet_cycles  = 0;
    int                  words_sent    = 0;
    int                  settings_run  = 0;
    logic [THR_W-1:0]    cur_four      = '0;
    logic [THR_W-1:0]    cur_eight     = '0;
    int                  origin_col;
    int                  origin_row;

    ising_metropolis_spin_flip_core u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .func                (func),
        .site                (site),
        .random              (random),
        .spin_value          (spin_value),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .accepted            (accepted),
        .delta_energy        (delta_energy),
        .total_magnetization (total_magnetization),
        .total_energy        (total_energy)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // The receiver decides afresh at every falling edge whether to hold off
    // the result channel; a stall percentage of zero leaves it always open.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result words are checked at the rising edge. The same process watches
    // for progress: any accepted word on any channel resets the quiet count,
    // and a run that goes quiet for too long is ended as a failure. The
    // clearing pass after reset is far shorter than the limit.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            seen_result.accepted      = accepted;
            seen_result.delta         = delta_energy;
            seen_result.magnetisation = total_magnetization;
            seen_result.energy        = total_energy;
            sb.check_result(seen_result);
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, sb.pending());
            $display("ising_metropolis_spin_flip_core test failed");
            $finish;
        end
    end

    // Offers one word, idling first as the current pattern asks, and hands it
    // to the scoreboard once the core has taken it. The valid line is left
    // high afterwards so that back-to-back words see no bubble.
    task automatic send_word(spin_word_t w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= w.func;
        site       <= w.site;
        random     <= w.frac;
        spin_value <= w.spin;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(w);
        words_sent++;
    endtask

    task automatic send_fields(logic f, int s, int frac, logic sv);
        spin_word_t w;
        w.func = f;
        w.site = SITE_W'(s);
        w.frac = RND_W'(frac);
        w.spin = sv;
        send_word(w);
    endtask

    // Holds the sender back until every predicted result word has arrived.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Empties the pipeline and lets it settle, so that the core is idle.
    task automatic drain();
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_threshold(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_thresholds(logic [THR_W-1:0] four, logic [THR_W-1:0] eight);
        cfg_write(REG_THRESH_FOUR, four);
        cfg_write(REG_THRESH_EIGHT, eight);
        cur_four  = four;
        cur_eight = eight;
        settings_run++;
    endtask

    // Picks a random fraction that often lands right on a threshold edge,
    // where an off-by-one in the compare would show.
    function automatic logic [RND_W-1:0] pick_fraction();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return cur_four + RND_W'($urandom_range(2)) - RND_W'(1);
            3:       return cur_eight + RND_W'($urandom_range(2)) - RND_W'(1);
            default: return RND_W'($urandom);
        endcase
    endfunction

    // Most words fall on a small patch across the wrapping corner or on an
    // eight by eight block, so that neighbourhoods keep changing and words
    // often hit the same or adjacent rows back to back. The rest roam freely.
    function automatic spin_word_t make_word();
        spin_word_t w;
        int         sel;
        int         col;
        int         row;
        sel = $urandom_range(9);
        if (sel < 5)
        begin
            col = ($urandom_range(3) + LW - 2) % LW;
            row = ($urandom_range(3) + LH - 2) % LH;
        end
        else if (sel < 8)
        begin
            col = (origin_col + $urandom_range(7)) % LW;
            row = (origin_row + $urandom_range(7)) % LH;
        end
        else
        begin
            col = $urandom_range(LW - 1);
            row = $urandom_range(LH - 1);
        end
        w.func = ($urandom_range(9) < 3) ? FUNC_WRITE : FUNC_PROPOSE;
        w.site = SITE_W'(col + row * LW);
        w.frac = pick_fraction();
        w.spin = 1'($urandom_range(1));
        return w;
    endfunction

    initial
    begin
        logic [THR_W-1:0] four_list[PHASES];
        logic [THR_W-1:0] eight_list[PHASES];
        logic [31:0]      squared;

        sb = new();

        // Reset is held low from the start and released on a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words with both thresholds at their reset value of zero:
        // no rise in energy can be accepted. The sequence takes site 0 and
        // its wrapped neighbours through every energy change.
        send_fields(FUNC_PROPOSE, 0, 16'h0000, 1'b0);     // +8, zero random rejected
        send_fields(FUNC_PROPOSE, SITES - 1, 16'hFFFF, 1'b1);
        send_fields(FUNC_WRITE, 0, 16'hFFFF, 1'b1);       // same spin, no change
        send_fields(FUNC_WRITE, 0, 16'h0000, 1'b0);       // forced flip despite +8
        send_fields(FUNC_WRITE, 0, 16'h0000, 1'b0);       // same spin again, reports -8
        send_fields(FUNC_PROPOSE, 0, 16'hFFFF, 1'b0);     // -8 always taken
        send_fields(FUNC_WRITE, LW - 1, 16'h0000, 1'b0);  // left neighbour across the wrap
        send_fields(FUNC_WRITE, SITES - LW, 16'h0000, 1'b0);  // lower neighbour across the wrap
        send_fields(FUNC_PROPOSE, 0, 16'hFFFF, 1'b1);     // zero change is taken
        send_fields(FUNC_WRITE, LW, 16'h0000, 1'b0);
        send_fields(FUNC_PROPOSE, 0, 16'h0000, 1'b1);     // +4 with zero threshold
        send_fields(FUNC_WRITE, 1, 16'h0000, 1'b0);
        send_fields(FUNC_PROPOSE, LW - 1, 16'h0000, 1'b0);    // -4 taken

        // The same corner against non-zero thresholds, probing both sides of
        // each compare: a fraction equal to the threshold must be refused.
        drain();
        set_thresholds(16'h4000, 16'h0100);
        send_fields(FUNC_PROPOSE, 0, 16'h4000, 1'b0);
        send_fields(FUNC_PROPOSE, 0, 16'h3FFF, 1'b0);
        send_fields(FUNC_WRITE, 0, 16'h0000, 1'b0);
        send_fields(FUNC_WRITE, LW - 1, 16'h0000, 1'b0);
        send_fields(FUNC_PROPOSE, 0, 16'h0100, 1'b1);
        send_fields(FUNC_PROPOSE, 0, 16'h00FF, 1'b1);
        send_fields(FUNC_WRITE, SITES - 1, 16'hFFFF, 1'b0);
        send_fields(FUNC_PROPOSE, SITES - 1, 16'h0000, 1'b1);
        send_fields(FUNC_PROPOSE, SITES / 2, 16'hFFFF, 1'b0);

        // Threshold settings of the random phases: the extremes, two fixed mixed
        // ones and two random temperatures where the eight threshold is the square
        // of the four threshold, as the Boltzmann factors would give.
        squared       = 32'($urandom_range(65535));
        four_list[0]  = 16'hFFFF;  eight_list[0] = 16'hFFFF;
        four_list[1]  = squared[15:0];
        squared       = squared * squared;
        eight_list[1] = squared[31:16];
        four_list[2]  = 16'h0000;  eight_list[2] = 16'h0000;
        four_list[3]  = 16'h4000;  eight_list[3] = 16'h0400;
        squared       = 32'($urandom_range(65535));
        four_list[4]  = squared[15:0];
        squared       = squared * squared;
        eight_list[4] = squared[31:16];
        four_list[5]  = 16'hFFFF;  eight_list[5] = 16'h0000;

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            set_thresholds(four_list[p], eight_list[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 75;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 75;
                end
                default:
                begin
                    send_idle_pct = 15;
                    stall_pct     = 15;
                end
            endcase
            origin_col = $urandom_range(LW - 1);
            origin_row = $urandom_range(LH - 1);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Midway through one phase the sender stops until the
                // pipeline has run completely dry, then carries on.
                if (p == 1 && n == PHASE_WORDS / 2)
                    wait_for_results();
                send_word(make_word());
            end
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        drain();

        $display("Covered %0d words under %0d threshold settings and four idling patterns;",
                 words_sent, settings_run);
        $display("%0d result words checked, %0d spins flipped, %0d errors.",
                 sb.checked, sb.flips, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ising_metropolis_spin_flip_core test passed");
        else
            $display("ising_metropolis_spin_flip_core test failed");
        $finish;
    end

endmodule
